// ===== hdl/mvm_pkg.sv =====
// Shared constants, types and helper functions of the memory-to-memory VM core.
package mvm_pkg;

   localparam int unsigned MEM_WORDS_DEF = 65536;

   localparam logic [1:0] FN_WRITE   = 2'd0;
   localparam logic [1:0] FN_READ    = 2'd1;
   localparam logic [1:0] FN_RESTART = 2'd2;
   localparam logic [1:0] FN_EXEC    = 2'd3;

   localparam logic [2:0] ST_CONT    = 3'd0;
   localparam logic [2:0] ST_HALT    = 3'd1;
   localparam logic [2:0] ST_LOOP    = 3'd2;
   localparam logic [2:0] ST_BADINST = 3'd3;
   localparam logic [2:0] ST_BADDATA = 3'd4;
   localparam logic [2:0] ST_BADJUMP = 3'd5;
   localparam logic [2:0] ST_BADOP   = 3'd6;
   localparam logic [2:0] ST_DIVZ    = 3'd7;

   localparam logic [1:0] CSR_DATA_BASE = 2'd0;
   localparam logic [1:0] CSR_MEM_LIMIT = 2'd1;
   localparam logic [1:0] CSR_MAX_CYCLES  = 2'd2;

   localparam logic [15:0] DATA_BASE_RST  = 16'd4096;
   localparam logic [16:0] MEM_LIMIT_RST  = 17'd65536;
   localparam logic [30:0] MAX_CYCLES_RST = 31'd500000000;

   localparam logic [31:0] OP_NOP    = 32'd0;
   localparam logic [31:0] OP_HLT    = 32'd1;
   localparam logic [31:0] OP_JA     = 32'd2;
   localparam logic [31:0] OP_JR     = 32'd3;
   localparam logic [31:0] OP_JNZ    = 32'd4;
   localparam logic [31:0] OP_JZ     = 32'd5;
   localparam logic [31:0] OP_JG     = 32'd6;
   localparam logic [31:0] OP_JGE    = 32'd7;
   localparam logic [31:0] OP_JL     = 32'd8;
   localparam logic [31:0] OP_JLE    = 32'd9;
   localparam logic [31:0] OP_LIA    = 32'd10;
   localparam logic [31:0] OP_LD     = 32'd11;
   localparam logic [31:0] OP_ST     = 32'd12;
   localparam logic [31:0] OP_STV    = 32'd13;
   localparam logic [31:0] OP_MOV    = 32'd14;
   localparam logic [31:0] OP_ADD    = 32'd15;
   localparam logic [31:0] OP_SUB    = 32'd16;
   localparam logic [31:0] OP_MUL    = 32'd17;
   localparam logic [31:0] OP_DIV    = 32'd18;
   localparam logic [31:0] OP_MOVV   = 32'd19;
   localparam logic [31:0] OP_ADDV   = 32'd20;
   localparam logic [31:0] OP_SUBV   = 32'd21;
   localparam logic [31:0] OP_MULV   = 32'd22;
   localparam logic [31:0] OP_DIVV   = 32'd23;
   localparam logic [31:0] OP_DBG    = 32'd24;
   localparam logic [31:0] OP_DBGEXT = 32'd25;

   typedef struct packed {
      logic        ok;
      logic [31:0] pc;
   } jump_type;

   // residue mod 3 of an unsigned word: base-4 digits each weigh 1 mod 3
   function automatic logic [1:0] mod3(input logic [31:0] v);
      logic [5:0] s;
      logic [3:0] t;
      logic [2:0] u;
      s = '0;
      for (int i = 0; i < 16; i++) begin
         s = s + 6'(v[2*i +: 2]);
      end
      t = 4'(s[1:0]) + 4'(s[3:2]) + 4'(s[5:4]);
      u = 3'(t[1:0]) + 3'(t[3:2]);
      if (u >= 3'd3) begin
         u = u - 3'd3;
      end
      return u[1:0];
   endfunction

   function automatic jump_type jump_to(input logic [31:0] base, input logic [31:0] rel,
                                        input logic [32:0] lim);
      jump_type   j;
      logic [31:0] t;
      logic [1:0]  r;
      logic        div3;
      t    = base + rel;
      r    = mod3(rel);
      // negative offsets are seen as rel + 2^32, and 2^32 is 1 mod 3
      div3 = rel[31] ? (r == 2'd1) : (r == 2'd0);
      j.ok = div3 && !t[31] && ({1'b0, t} < lim);
      j.pc = t + 32'd3;
      return j;
   endfunction

   function automatic logic cond_true(input logic [31:0] op, input logic [31:0] v);
      logic r;
      case (op) inside
         OP_JNZ:  r = (v != '0);
         OP_JZ:   r = (v == '0);
         OP_JG:   r = !v[31] && (v != '0);
         OP_JGE:  r = !v[31];
         OP_JL:   r = v[31];
         default: r = v[31] || (v == '0);
      endcase
      return r;
   endfunction

endpackage

// ===== hdl/mvm_ifs.sv =====
// Request and response channel interfaces of the VM core.
interface mvm_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         func;
   logic [15:0]        addr;
   logic signed [31:0] data;
   modport source (output valid, func, addr, data, input ready);
   modport sink   (input valid, func, addr, data, output ready);
endinterface

interface mvm_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         status;
   logic signed [31:0] read_data;
   logic signed [31:0] program_counter;
   logic [30:0]        cycle_count;
   modport source (output valid, status, read_data, program_counter, cycle_count,
                   input ready);
   modport sink   (input valid, status, read_data, program_counter, cycle_count,
                   output ready);
endinterface

// ===== hdl/memory_to_memory_vm_core.sv =====
// Memory-to-memory VM core: word store, fetch/decode sequencer and shared ALU/divider.
//
// One item at a time. After reset the word store is cleared one word per cycle, every
// word of MEM_WORDS, before the first item is taken. A write or restart is answered
// straight from idle, a read after one store read, and an instruction with a bad fetch
// address straight away; any other executed instruction passes through the single-port
// store (three fetch reads, up to two operand reads, one write-back); divides add the
// one-bit-per-cycle divider (32 steps and a sign fix). The result is held on rsp_ch until
// taken; req_ch.ready is high only while the core is idle.
module memory_to_memory_vm_core #(
   parameter int unsigned MEM_WORDS = mvm_pkg::MEM_WORDS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   mvm_req_if.sink     req_ch,
   mvm_rsp_if.source   rsp_ch,
   input  logic        csr_we,
   input  logic [1:0]  csr_idx,
   input  logic [30:0] csr_wdata
);

   localparam int unsigned AW = $clog2(MEM_WORDS);

   localparam logic [4:0] S_CLEAR = 5'd0;
   localparam logic [4:0] S_IDLE  = 5'd1;
   localparam logic [4:0] S_RDW   = 5'd2;
   localparam logic [4:0] S_RSP   = 5'd3;
   localparam logic [4:0] S_F0    = 5'd4;
   localparam logic [4:0] S_F1    = 5'd5;
   localparam logic [4:0] S_F2    = 5'd6;
   localparam logic [4:0] S_DEC   = 5'd7;
   localparam logic [4:0] S_J2    = 5'd8;
   localparam logic [4:0] S_CND   = 5'd9;
   localparam logic [4:0] S_LD1   = 5'd10;
   localparam logic [4:0] S_ST1   = 5'd11;
   localparam logic [4:0] S_ST13  = 5'd12;
   localparam logic [4:0] S_A1    = 5'd13;
   localparam logic [4:0] S_A2    = 5'd14;
   localparam logic [4:0] S_DIV   = 5'd15;
   localparam logic [4:0] S_DFIN  = 5'd16;
   localparam logic [4:0] S_WR    = 5'd17;
   localparam logic [4:0] S_WRQ   = 5'd18;

   logic [4:0]  st_ff, st_in;
   logic [15:0] off_ff;
   logic [16:0] lim_ff;
   logic [30:0] max_ff;
   logic [AW-1:0] clr_ff, clr_in;
   logic [31:0] pc_ff, pc_in, ia_ff, ia_in, op_ff, op_in, a1_ff, a1_in, a2_ff, a2_in;
   logic [30:0] cyc_ff, cyc_in;
   logic [AW-1:0] xa_ff, xa_in;
   logic [31:0] yv_ff, yv_in, res_ff, res_in, rd_ff, rd_in;
   logic [2:0]  status_ff, status_in;
   logic [31:0] rem_ff, rem_in, quo_ff, quo_in, dmag_ff, dmag_in;
   logic        neg_ff, neg_in;
   logic [4:0]  cnt_ff, cnt_in;

   logic [31:0] mem [MEM_WORDS];
   logic [31:0] rdata_ff;
   logic          mem_we;
   logic [AW-1:0] mem_a;
   logic [31:0]   mem_wd;

   logic [32:0] lim33;
   logic [31:0] off32, xsum, ysum, qsum, ia_new, xmag, ymag;
   logic        okx, oky, okq, port_ok, bad_fetch, cyc_hit;
   logic [30:0] cyc_next;
   logic [32:0] rem_sh, diff;
   mvm_pkg::jump_type j_rel, j_abs;

   assign lim33     = (33'(lim_ff) < 33'(MEM_WORDS)) ? 33'(lim_ff) : 33'(MEM_WORDS);
   assign off32     = 32'(off_ff);
   assign xsum      = a1_ff + off32;
   assign ysum      = a2_ff + off32;
   assign qsum      = rdata_ff + off32;
   assign okx       = {1'b0, xsum} < lim33;
   assign oky       = {1'b0, ysum} < lim33;
   assign okq       = {1'b0, qsum} < lim33;
   assign port_ok   = 32'(req_ch.addr) < 32'(MEM_WORDS);
   assign ia_new    = pc_ff - 32'd3;
   assign bad_fetch = ia_new[31] || (({1'b0, ia_new} + 33'd2) >= lim33);
   assign cyc_next  = cyc_ff + 31'd1;
   assign cyc_hit   = cyc_next >= max_ff;
   assign j_rel     = mvm_pkg::jump_to(ia_ff, a1_ff, lim33);
   assign j_abs     = mvm_pkg::jump_to(off32 - 32'd3, rdata_ff + 32'd1, lim33);
   assign xmag      = rdata_ff[31] ? (32'd0 - rdata_ff) : rdata_ff;
   assign ymag      = yv_ff[31] ? (32'd0 - yv_ff) : yv_ff;
   assign rem_sh    = {rem_ff, quo_ff[31]};
   assign diff      = rem_sh - {1'b0, dmag_ff};

   assign req_ch.ready           = (st_ff == S_IDLE);
   assign rsp_ch.valid           = (st_ff == S_RSP);
   assign rsp_ch.status          = status_ff;
   assign rsp_ch.read_data       = rd_ff;
   assign rsp_ch.program_counter = pc_ff;
   assign rsp_ch.cycle_count     = cyc_ff;

   always_comb begin
      st_in = st_ff;  clr_in = clr_ff;  pc_in = pc_ff;  ia_in = ia_ff;
      op_in = op_ff;  a1_in = a1_ff;  a2_in = a2_ff;  cyc_in = cyc_ff;
      xa_in = xa_ff;  yv_in = yv_ff;  res_in = res_ff;  rd_in = rd_ff;
      status_in = status_ff;  rem_in = rem_ff;  quo_in = quo_ff;
      dmag_in = dmag_ff;  neg_in = neg_ff;  cnt_in = cnt_ff;
      mem_we = 1'b0;  mem_a = '0;  mem_wd = '0;

      unique case (st_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_a  = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(MEM_WORDS - 1)) begin
               st_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_ch.valid) begin
               status_in = mvm_pkg::ST_CONT;
               rd_in     = '0;
               st_in     = S_RSP;
               unique case (req_ch.func)
                  mvm_pkg::FN_WRITE: begin
                     mem_we = port_ok;
                     mem_a  = AW'(req_ch.addr);
                     mem_wd = req_ch.data;
                  end
                  mvm_pkg::FN_READ: begin
                     mem_a = AW'(req_ch.addr);
                     if (port_ok) begin
                        st_in = S_RDW;
                     end
                  end
                  mvm_pkg::FN_RESTART: begin
                     pc_in  = off32;
                     cyc_in = '0;
                  end
                  default: begin
                     pc_in = ia_new;
                     ia_in = ia_new;
                     mem_a = AW'(ia_new + 32'd2);
                     if (bad_fetch) begin
                        status_in = mvm_pkg::ST_BADINST;
                     end else begin
                        st_in = S_F0;
                     end
                  end
               endcase
            end
         end
         S_RDW: begin
            rd_in = rdata_ff;
            st_in = S_RSP;
         end
         S_RSP: begin
            if (rsp_ch.ready) begin
               st_in = S_IDLE;
            end
         end
         S_F0: begin
            op_in = rdata_ff;
            mem_a = AW'(ia_ff + 32'd1);
            st_in = S_F1;
         end
         S_F1: begin
            a1_in = rdata_ff;
            mem_a = AW'(ia_ff);
            st_in = S_F2;
         end
         S_F2: begin
            a2_in = rdata_ff;
            st_in = S_DEC;
         end
         S_DEC: begin
            st_in     = S_RSP;
            status_in = mvm_pkg::ST_BADDATA;
            xa_in     = AW'(xsum);
            case (op_ff) inside
               mvm_pkg::OP_NOP, mvm_pkg::OP_DBGEXT: begin
                  cyc_in    = cyc_next;
                  status_in = cyc_hit ? mvm_pkg::ST_LOOP : mvm_pkg::ST_CONT;
               end
               mvm_pkg::OP_HLT: status_in = mvm_pkg::ST_HALT;
               mvm_pkg::OP_JA: begin
                  mem_a = AW'(xsum);
                  if (okx) st_in = S_J2;
               end
               mvm_pkg::OP_JR: begin
                  if (j_rel.ok) begin
                     pc_in     = j_rel.pc;
                     cyc_in    = cyc_next;
                     status_in = cyc_hit ? mvm_pkg::ST_LOOP : mvm_pkg::ST_CONT;
                  end else begin
                     status_in = mvm_pkg::ST_BADJUMP;
                  end
               end
               mvm_pkg::OP_JNZ, mvm_pkg::OP_JZ, mvm_pkg::OP_JG, mvm_pkg::OP_JGE,
               mvm_pkg::OP_JL, mvm_pkg::OP_JLE: begin
                  mem_a = AW'(ysum);
                  if (oky) st_in = S_CND;
               end
               mvm_pkg::OP_LIA: begin
                  if (okx) begin
                     mem_we    = 1'b1;
                     mem_a     = AW'(xsum);
                     mem_wd    = ia_ff + 32'd2 + a2_ff - off32;
                     cyc_in    = cyc_next;
                     status_in = cyc_hit ? mvm_pkg::ST_LOOP : mvm_pkg::ST_CONT;
                  end
               end
               mvm_pkg::OP_LD: begin
                  mem_a = AW'(ysum);
                  if (okx && oky) st_in = S_LD1;
               end
               mvm_pkg::OP_ST: begin
                  mem_a = AW'(xsum);
                  if (okx) st_in = S_ST1;
               end
               mvm_pkg::OP_STV: begin
                  mem_a = AW'(xsum);
                  if (okx) st_in = S_ST13;
               end
               mvm_pkg::OP_MOV, mvm_pkg::OP_ADD, mvm_pkg::OP_SUB, mvm_pkg::OP_MUL,
               mvm_pkg::OP_DIV: begin
                  mem_a = AW'(ysum);
                  if (okx && oky) st_in = S_A1;
               end
               mvm_pkg::OP_MOVV, mvm_pkg::OP_ADDV, mvm_pkg::OP_SUBV, mvm_pkg::OP_MULV,
               mvm_pkg::OP_DIVV: begin
                  yv_in = a2_ff;
                  mem_a = AW'(xsum);
                  if (okx) st_in = S_A2;
               end
               mvm_pkg::OP_DBG: begin
                  if (okx) begin
                     cyc_in    = cyc_next;
                     status_in = cyc_hit ? mvm_pkg::ST_LOOP : mvm_pkg::ST_CONT;
                  end
               end
               default: status_in = mvm_pkg::ST_BADOP;
            endcase
         end
         S_J2: begin
            st_in = S_RSP;
            if (j_abs.ok) begin
               pc_in     = j_abs.pc;
               cyc_in    = cyc_next;
               status_in = cyc_hit ? mvm_pkg::ST_LOOP : mvm_pkg::ST_CONT;
            end else begin
               status_in = mvm_pkg::ST_BADJUMP;
            end
         end
         S_CND: begin
            st_in = S_RSP;
            if (mvm_pkg::cond_true(op_ff, rdata_ff) && !j_rel.ok) begin
               status_in = mvm_pkg::ST_BADJUMP;
            end else begin
               if (mvm_pkg::cond_true(op_ff, rdata_ff)) pc_in = j_rel.pc;
               cyc_in    = cyc_next;
               status_in = cyc_hit ? mvm_pkg::ST_LOOP : mvm_pkg::ST_CONT;
            end
         end
         S_LD1: begin
            // pointer word just read; fetch what it points at
            mem_a = AW'(qsum);
            if (okq) begin
               st_in = S_WRQ;
            end else begin
               status_in = mvm_pkg::ST_BADDATA;
               st_in     = S_RSP;
            end
         end
         S_ST1: begin
            xa_in = AW'(qsum);
            mem_a = AW'(ysum);
            if (okq && oky) begin
               st_in = S_WRQ;
            end else begin
               status_in = mvm_pkg::ST_BADDATA;
               st_in     = S_RSP;
            end
         end
         S_ST13: begin
            st_in = S_RSP;
            if (okq) begin
               mem_we    = 1'b1;
               mem_a     = AW'(qsum);
               mem_wd    = a2_ff;
               cyc_in    = cyc_next;
               status_in = cyc_hit ? mvm_pkg::ST_LOOP : mvm_pkg::ST_CONT;
            end else begin
               status_in = mvm_pkg::ST_BADDATA;
            end
         end
         S_A1: begin
            yv_in = rdata_ff;
            mem_a = xa_ff;
            st_in = S_A2;
         end
         S_A2: begin
            st_in = S_WR;
            case (op_ff) inside
               mvm_pkg::OP_ADD, mvm_pkg::OP_ADDV: res_in = rdata_ff + yv_ff;
               mvm_pkg::OP_SUB, mvm_pkg::OP_SUBV: res_in = rdata_ff - yv_ff;
               mvm_pkg::OP_MUL, mvm_pkg::OP_MULV: res_in = 32'(rdata_ff * yv_ff);
               mvm_pkg::OP_DIV, mvm_pkg::OP_DIVV: begin
                  neg_in  = rdata_ff[31] ^ yv_ff[31];
                  quo_in  = xmag;
                  dmag_in = ymag;
                  rem_in  = '0;
                  cnt_in  = '0;
                  if (yv_ff == '0) begin
                     status_in = mvm_pkg::ST_DIVZ;
                     st_in     = S_RSP;
                  end else begin
                     st_in = S_DIV;
                  end
               end
               default: res_in = yv_ff;
            endcase
         end
         S_DIV: begin
            // restoring divide, one quotient bit per cycle
            rem_in = diff[32] ? rem_sh[31:0] : diff[31:0];
            quo_in = {quo_ff[30:0], ~diff[32]};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               st_in = S_DFIN;
            end
         end
         S_DFIN: begin
            res_in = neg_ff ? (32'd0 - quo_ff) : quo_ff;
            st_in  = S_WR;
         end
         S_WR: begin
            mem_we    = 1'b1;
            mem_a     = xa_ff;
            mem_wd    = res_ff;
            cyc_in    = cyc_next;
            status_in = cyc_hit ? mvm_pkg::ST_LOOP : mvm_pkg::ST_CONT;
            st_in     = S_RSP;
         end
         S_WRQ: begin
            mem_we    = 1'b1;
            mem_a     = xa_ff;
            mem_wd    = rdata_ff;
            cyc_in    = cyc_next;
            status_in = cyc_hit ? mvm_pkg::ST_LOOP : mvm_pkg::ST_CONT;
            st_in     = S_RSP;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_a] <= mem_wd;
      end else begin
         rdata_ff <= mem[mem_a];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= S_CLEAR;
         clr_ff <= '0;
         pc_ff  <= '0;
         cyc_ff <= '0;
         off_ff <= mvm_pkg::DATA_BASE_RST;
         lim_ff <= mvm_pkg::MEM_LIMIT_RST;
         max_ff <= mvm_pkg::MAX_CYCLES_RST;
      end else begin
         st_ff  <= st_in;
         clr_ff <= clr_in;
         pc_ff  <= pc_in;
         cyc_ff <= cyc_in;
         if (csr_we) begin
            unique case (csr_idx)
               mvm_pkg::CSR_DATA_BASE:  off_ff <= csr_wdata[15:0];
               mvm_pkg::CSR_MEM_LIMIT:  lim_ff <= csr_wdata[16:0];
               mvm_pkg::CSR_MAX_CYCLES: max_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      ia_ff     <= ia_in;
      op_ff     <= op_in;
      a1_ff     <= a1_in;
      a2_ff     <= a2_in;
      xa_ff     <= xa_in;
      yv_ff     <= yv_in;
      res_ff    <= res_in;
      rd_ff     <= rd_in;
      status_ff <= status_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      dmag_ff   <= dmag_in;
      neg_ff    <= neg_in;
      cnt_ff    <= cnt_in;
   end

   a_busy_when_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !req_ch.ready)
      else $error("request taken while a response is pending");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_DIV) |-> (dmag_ff != '0))
      else $error("divider running with zero divisor");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && req_ch.func == mvm_pkg::FN_RESTART)
      |=> (cyc_ff == '0) && (pc_ff == 32'($past(off_ff))))
      else $error("restart did not reset pc and cycle count");

   a_err_keeps_cycles: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !$past(rsp_ch.valid) && status_ff > mvm_pkg::ST_LOOP)
      |-> (cyc_ff == $past(cyc_ff)))
      else $error("cycle count moved on an error status");

endmodule
